// ===== rtl/nqpt_pkg.sv =====
package nqpt_pkg;

  localparam int CfgW    = 7;
  localparam int IdxW    = 6;
  localparam int TagW    = 16;
  localparam int StatusW = 15;
  localparam int DwW     = 32;

  localparam logic ACT_SUBMIT   = 1'b0;
  localparam logic ACT_COMPLETE = 1'b1;

  typedef enum logic [2:0] {
    OUT_SUBMITTED = 3'd0,
    OUT_FULL      = 3'd1,
    OUT_CONSUMED  = 3'd2,
    OUT_NO_NEW    = 3'd3,
    OUT_STALE     = 3'd4
  } outcome_e;

  typedef struct packed {
    logic            found;
    logic [IdxW-1:0] id;
  } alloc_t;

  // ring pointer step; a pointer at or past the last slot wraps to zero
  function automatic logic [IdxW-1:0] ring_advance(logic [IdxW-1:0] idx,
                                                   logic [CfgW-1:0] size);
    logic [CfgW-1:0] nxt;
    nxt = {1'b0, idx} + CfgW'(1);
    return (nxt >= size) ? '0 : nxt[IdxW-1:0];
  endfunction

endpackage

// ===== rtl/nqpt_id_alloc.sv =====
module nqpt_id_alloc #(
  parameter int ID_CAP = 64
) (
  input  logic [ID_CAP-1:0]           busy_i,
  input  logic [nqpt_pkg::CfgW-1:0]   size_i,
  output nqpt_pkg::alloc_t            alloc_o
);
  import nqpt_pkg::*;

  // lowest free id below size-1; scan from the top so the lowest wins
  always_comb begin
    alloc_o.found = 1'b0;
    alloc_o.id    = '0;
    for (int i = ID_CAP - 1; i >= 0; i--) begin
      if (!busy_i[i] && (CfgW'(i + 1) < size_i)) begin
        alloc_o.found = 1'b1;
        alloc_o.id    = IdxW'(i);
      end
    end
  end

endmodule

// ===== rtl/nqpt_tag_store.sv =====
module nqpt_tag_store #(
  parameter int DEPTH = 64
) (
  input  logic                        clk_i,
  input  logic                        we_i,
  input  logic [$clog2(DEPTH)-1:0]    waddr_i,
  input  logic [nqpt_pkg::TagW-1:0]   wdata_i,
  input  logic [$clog2(DEPTH)-1:0]    raddr_i,
  output logic [nqpt_pkg::TagW-1:0]   rdata_o
);
  import nqpt_pkg::*;

  logic [TagW-1:0] mem [DEPTH];
  logic [TagW-1:0] rdata_q;

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem[waddr_i] <= wdata_i;
    end
  end

  // forward a same-cycle write so the next stage sees the fresh tag
  always_ff @(posedge clk_i) begin
    if (we_i && (waddr_i == raddr_i)) begin
      rdata_q <= wdata_i;
    end else begin
      rdata_q <= mem[raddr_i];
    end
  end

  assign rdata_o = rdata_q;

endmodule

// ===== rtl/nvme_queue_pair_tracker_top.sv =====
// Host-side tracker for one NVMe submission/completion queue pair.
// Command channel: drive the payload with start_i high for one cycle; the
// transaction is taken on any edge with start_i high and busy_o low. busy_o
// stays low, so one transaction may be issued every clock.
// action_i = 0 allocates the lowest free command id, stores request_tag_i
// and reports slot and new submission tail doorbell, or reports full.
// action_i = 1 examines the completion entry at head: a matching phase frees
// a busy id, returning tag, status and dword 0, or reports stale; a mismatch
// ends the batch, asking for a head doorbell write if anything was consumed.
// Result channel: done_o marks exactly one cycle carrying the result; the
// receiver must take it then. An accepted transaction passes the input
// register, the single compute stage and the result register, which drives
// done_o and the result; throughput is one transaction per cycle.
// Config: cfg_we_i writes cfg_wdata_i to queue_entries (clamped to
// [2, min(QUEUE_DEPTH, 64)]); write only while no transaction is in flight.
// Reset: all ids free, both pointers zero, expected phase one, size 64
// (clamped). Tag storage is not cleared; it is read only for busy ids.
module nvme_queue_pair_tracker_top #(
  parameter int QUEUE_DEPTH = 64
) (
  input  logic                           clk_i,
  input  logic                           rst_ni,
  input  logic                           start_i,
  output logic                           busy_o,
  input  logic                           cfg_we_i,
  input  logic [nqpt_pkg::CfgW-1:0]      cfg_wdata_i,
  input  logic                           action_i,
  input  logic [nqpt_pkg::TagW-1:0]      request_tag_i,
  input  logic                           cq_phase_tag_i,
  input  logic [nqpt_pkg::StatusW-1:0]   cq_status_i,
  input  logic [nqpt_pkg::IdxW-1:0]      cq_command_id_i,
  input  logic [nqpt_pkg::DwW-1:0]       cq_dword0_i,
  output logic                           done_o,
  output logic [2:0]                     outcome_o,
  output logic [nqpt_pkg::IdxW-1:0]      command_id_o,
  output logic [nqpt_pkg::IdxW-1:0]      slot_index_o,
  output logic [nqpt_pkg::TagW-1:0]      tag_out_o,
  output logic [nqpt_pkg::StatusW-1:0]   status_out_o,
  output logic [nqpt_pkg::DwW-1:0]       dword0_out_o,
  output logic                           doorbell_write_o,
  output logic [nqpt_pkg::IdxW-1:0]      doorbell_value_o
);
  import nqpt_pkg::*;

  localparam int IdCap = (QUEUE_DEPTH < 64) ? QUEUE_DEPTH : 64;
  localparam int IdW   = $clog2(IdCap);
  localparam logic [CfgW-1:0] SizeRst = CfgW'(IdCap);

  // configuration, stored already clamped
  logic [CfgW-1:0] size_q;
  logic [CfgW-1:0] size_d;

  always_comb begin
    size_d = cfg_wdata_i;
    if (size_d < CfgW'(2)) begin
      size_d = CfgW'(2);
    end
    if (size_d > SizeRst) begin
      size_d = SizeRst;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      size_q <= SizeRst;
    end else if (cfg_we_i) begin
      size_q <= size_d;
    end
  end

  // input register
  logic               valid_q;
  logic               action_q;
  logic [TagW-1:0]    req_tag_q;
  logic               phase_q;
  logic [StatusW-1:0] status_q;
  logic [IdxW-1:0]    cid_q;
  logic [DwW-1:0]     dw0_q;

  assign busy_o = 1'b0;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
    end else begin
      valid_q <= start_i && !busy_o;
    end
  end

  always_ff @(posedge clk_i) begin
    if (start_i && !busy_o) begin
      action_q  <= action_i;
      req_tag_q <= request_tag_i;
      phase_q   <= cq_phase_tag_i;
      status_q  <= cq_status_i;
      cid_q     <= cq_command_id_i;
      dw0_q     <= cq_dword0_i;
    end
  end

  // queue state
  logic [IdCap-1:0] busy_map_q, busy_map_d;
  logic [IdxW-1:0]  sq_tail_q, sq_tail_d;
  logic [IdxW-1:0]  cq_head_q, cq_head_d;
  logic             exp_phase_q, exp_phase_d;
  logic             batch_q, batch_d;

  alloc_t          alloc;
  logic [TagW-1:0] tag_rd;
  logic            tag_we;
  logic [IdW-1:0]  cid_idx;
  logic            cid_busy;
  logic [IdxW-1:0] tail_next;
  logic [IdxW-1:0] head_next;

  nqpt_id_alloc #(
    .ID_CAP (IdCap)
  ) u_id_alloc (
    .busy_i  (busy_map_q),
    .size_i  (size_q),
    .alloc_o (alloc)
  );

  assign tag_we = valid_q && (action_q == ACT_SUBMIT) && alloc.found;

  nqpt_tag_store #(
    .DEPTH (IdCap)
  ) u_tag_store (
    .clk_i   (clk_i),
    .we_i    (tag_we),
    .waddr_i (alloc.id[IdW-1:0]),
    .wdata_i (req_tag_q),
    .raddr_i (cq_command_id_i[IdW-1:0]),
    .rdata_o (tag_rd)
  );

  assign cid_idx   = cid_q[IdW-1:0];
  assign cid_busy  = ({1'b0, cid_q} < CfgW'(IdCap)) && busy_map_q[cid_idx];
  assign tail_next = ring_advance(sq_tail_q, size_q);
  assign head_next = ring_advance(cq_head_q, size_q);

  // result staging
  outcome_e           outcome_d, outcome_q;
  logic [IdxW-1:0]    cmd_id_d, cmd_id_q;
  logic [IdxW-1:0]    slot_d, slot_q;
  logic [TagW-1:0]    tag_d, tag_q;
  logic [StatusW-1:0] stat_d, stat_q;
  logic [DwW-1:0]     dw0_d, dw0_out_q;
  logic               db_wr_d, db_wr_q;
  logic [IdxW-1:0]    db_val_d, db_val_q;
  logic               done_q;

  always_comb begin
    busy_map_d  = busy_map_q;
    sq_tail_d   = sq_tail_q;
    cq_head_d   = cq_head_q;
    exp_phase_d = exp_phase_q;
    batch_d     = batch_q;
    outcome_d   = OUT_FULL;
    cmd_id_d    = '0;
    slot_d      = '0;
    tag_d       = '0;
    stat_d      = '0;
    dw0_d       = '0;
    db_wr_d     = 1'b0;
    db_val_d    = '0;
    if (valid_q) begin
      if (action_q == ACT_SUBMIT) begin
        if (alloc.found) begin
          busy_map_d[alloc.id[IdW-1:0]] = 1'b1;
          sq_tail_d = tail_next;
          outcome_d = OUT_SUBMITTED;
          cmd_id_d  = alloc.id;
          slot_d    = sq_tail_q;
          db_wr_d   = 1'b1;
          db_val_d  = tail_next;
        end
      end else if (phase_q == exp_phase_q) begin
        cmd_id_d  = cid_q;
        if (cid_busy) begin
          busy_map_d[cid_idx] = 1'b0;
          outcome_d = OUT_CONSUMED;
          tag_d     = tag_rd;
          stat_d    = status_q;
          dw0_d     = dw0_q;
        end else begin
          outcome_d = OUT_STALE;
        end
        cq_head_d = head_next;
        // phase flips each time the head wraps
        if (head_next == '0) begin
          exp_phase_d = !exp_phase_q;
        end
        batch_d = 1'b1;
      end else begin
        outcome_d = OUT_NO_NEW;
        if (batch_q) begin
          db_wr_d  = 1'b1;
          db_val_d = cq_head_q;
          batch_d  = 1'b0;
        end
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_map_q  <= '0;
      sq_tail_q   <= '0;
      cq_head_q   <= '0;
      exp_phase_q <= 1'b1;
      batch_q     <= 1'b0;
      done_q      <= 1'b0;
    end else begin
      busy_map_q  <= busy_map_d;
      sq_tail_q   <= sq_tail_d;
      cq_head_q   <= cq_head_d;
      exp_phase_q <= exp_phase_d;
      batch_q     <= batch_d;
      done_q      <= valid_q;
    end
  end

  always_ff @(posedge clk_i) begin
    if (valid_q) begin
      outcome_q <= outcome_d;
      cmd_id_q  <= cmd_id_d;
      slot_q    <= slot_d;
      tag_q     <= tag_d;
      stat_q    <= stat_d;
      dw0_out_q <= dw0_d;
      db_wr_q   <= db_wr_d;
      db_val_q  <= db_val_d;
    end
  end

  assign done_o           = done_q;
  assign outcome_o        = outcome_q;
  assign command_id_o     = cmd_id_q;
  assign slot_index_o     = slot_q;
  assign tag_out_o        = tag_q;
  assign status_out_o     = stat_q;
  assign dword0_out_o     = dw0_out_q;
  assign doorbell_write_o = db_wr_q;
  assign doorbell_value_o = db_val_q;

endmodule

// ===== test/nvme_queue_pair_tracker_top_tb.sv =====
`timescale 1ns / 100ps

module nvme_queue_pair_tracker_top_tb;
  import nqpt_pkg::*;

  localparam int QDEPTH = 64;

  typedef struct packed {
    logic                 action;
    logic [TagW-1:0]      req_tag;
    logic                 phase;
    logic [StatusW-1:0]   status;
    logic [IdxW-1:0]      cid;
    logic [DwW-1:0]       dw0;
  } host_op_t;

  typedef struct packed {
    outcome_e             outcome;
    logic [IdxW-1:0]      cmd_id;
    logic [IdxW-1:0]      slot;
    logic [TagW-1:0]      tag;
    logic [StatusW-1:0]   status;
    logic [DwW-1:0]       dw0;
    logic                 db_wr;
    logic [IdxW-1:0]      db_val;
  } qp_outcome_t;

  typedef struct packed {
    logic [63:0]           busy;
    logic [63:0][TagW-1:0] tags;
    logic [IdxW-1:0]       sq_tail;
    logic [IdxW-1:0]       cq_head;
    logic                  phase;
    logic                  batch;
    logic [CfgW-1:0]       size;
  } qpair_state_t;

  logic                clk_i           = 1'b0;
  logic                rst_ni          = 1'b0;
  logic                start_i         = 1'b0;
  logic                cfg_we_i        = 1'b0;
  logic [CfgW-1:0]     cfg_wdata_i     = '0;
  logic                action_i        = 1'b0;
  logic [TagW-1:0]     request_tag_i   = '0;
  logic                cq_phase_tag_i  = 1'b0;
  logic [StatusW-1:0]  cq_status_i     = '0;
  logic [IdxW-1:0]     cq_command_id_i = '0;
  logic [DwW-1:0]      cq_dword0_i     = '0;
  logic                busy_o;
  logic                done_o;
  logic [2:0]          outcome_o;
  logic [IdxW-1:0]     command_id_o;
  logic [IdxW-1:0]     slot_index_o;
  logic [TagW-1:0]     tag_out_o;
  logic [StatusW-1:0]  status_out_o;
  logic [DwW-1:0]      dword0_out_o;
  logic                doorbell_write_o;
  logic [IdxW-1:0]     doorbell_value_o;

  nvme_queue_pair_tracker_top #(
    .QUEUE_DEPTH(QDEPTH)
  ) u_dut (
    .clk_i           (clk_i),
    .rst_ni          (rst_ni),
    .start_i         (start_i),
    .busy_o          (busy_o),
    .cfg_we_i        (cfg_we_i),
    .cfg_wdata_i     (cfg_wdata_i),
    .action_i        (action_i),
    .request_tag_i   (request_tag_i),
    .cq_phase_tag_i  (cq_phase_tag_i),
    .cq_status_i     (cq_status_i),
    .cq_command_id_i (cq_command_id_i),
    .cq_dword0_i     (cq_dword0_i),
    .done_o          (done_o),
    .outcome_o       (outcome_o),
    .command_id_o    (command_id_o),
    .slot_index_o    (slot_index_o),
    .tag_out_o       (tag_out_o),
    .status_out_o    (status_out_o),
    .dword0_out_o    (dword0_out_o),
    .doorbell_write_o(doorbell_write_o),
    .doorbell_value_o(doorbell_value_o)
  );

  host_op_t     host_ops[$];
  qp_outcome_t  predicted_outcomes[$];
  qpair_state_t tracked;   // follows accepted transactions
  qpair_state_t planned;   // follows generated transactions, used to shape stimulus
  host_op_t     cur_op;
  int           gap_left = 0;
  bit           no_idle  = 1'b0;
  int           errors   = 0;
  int           n_ops = 0, n_sub = 0, n_full = 0, n_cons = 0, n_stale = 0, n_nonew = 0;
  int           n_db = 0, n_cfg = 0;

  initial begin
    forever #10 clk_i = ~clk_i;
  end

  initial begin
    #(2_000_000);
    $display("timeout at %0t", $time);
    $display("simulation failed");
    $finish;
  end

  function automatic qpair_state_t qp_reset_state();
    qpair_state_t st;
    st = '0;
    st.phase = 1'b1;
    st.size  = CfgW'(64);
    return st;
  endfunction

  // queue_entries clamped to [2, min(depth, 64)]
  function automatic int ring_size(logic [CfgW-1:0] q);
    int cap;
    cap = (QDEPTH < 64) ? QDEPTH : 64;
    if (cap < 2) cap = 2;
    if (q < 2) return 2;
    if (int'(q) > cap) return cap;
    return int'(q);
  endfunction

  function automatic logic [IdxW-1:0] ring_next(logic [IdxW-1:0] idx, int e);
    return (int'(idx) + 1 >= e) ? '0 : idx + IdxW'(1);
  endfunction

  function automatic qp_outcome_t apply_host_op(inout qpair_state_t st, input host_op_t op);
    qp_outcome_t r;
    int          e;
    int          free_id;
    r = '0;
    e = ring_size(st.size);
    if (op.action == ACT_SUBMIT) begin
      free_id = -1;
      // at most e-1 outstanding, so ids come from 0..e-2
      for (int i = 0; i < e - 1; i++)
        if (!st.busy[i] && free_id < 0) free_id = i;
      if (free_id < 0) begin
        r.outcome = OUT_FULL;
      end else begin
        st.busy[free_id] = 1'b1;
        st.tags[free_id] = op.req_tag;
        r.outcome = OUT_SUBMITTED;
        r.cmd_id  = IdxW'(free_id);
        r.slot    = st.sq_tail;
        st.sq_tail = ring_next(st.sq_tail, e);
        r.db_wr   = 1'b1;
        r.db_val  = st.sq_tail;
      end
    end else if (op.phase == st.phase) begin
      r.cmd_id = op.cid;
      if (st.busy[op.cid]) begin
        r.outcome = OUT_CONSUMED;
        r.tag     = st.tags[op.cid];
        r.status  = op.status;
        r.dw0     = op.dw0;
        st.busy[op.cid] = 1'b0;
      end else begin
        r.outcome = OUT_STALE;
      end
      st.cq_head = ring_next(st.cq_head, e);
      if (st.cq_head == '0) st.phase = ~st.phase;
      st.batch = 1'b1;
    end else begin
      r.outcome = OUT_NO_NEW;
      if (st.batch) begin
        r.db_wr  = 1'b1;
        r.db_val = st.cq_head;
        st.batch = 1'b0;
      end
    end
    return r;
  endfunction

  function automatic void check_field(string name, logic [31:0] want, logic [31:0] got);
    if (got !== want) begin
      errors++;
      $display("%0t mismatch %s: expected %0h actual %0h", $time, name, want, got);
    end
  endfunction

  // driver: one transaction in flight on the bus, random gaps between them
  always @(posedge clk_i) begin
    if (rst_ni) begin
      if (cfg_we_i) tracked.size = cfg_wdata_i;
      if (start_i && !busy_o) predicted_outcomes.push_back(apply_host_op(tracked, cur_op));
      if (!(start_i && busy_o)) begin
        if (gap_left > 0) begin
          gap_left--;
          start_i <= 1'b0;
        end else if (host_ops.size() > 0) begin
          cur_op = host_ops.pop_front();
          action_i        <= cur_op.action;
          request_tag_i   <= cur_op.req_tag;
          cq_phase_tag_i  <= cur_op.phase;
          cq_status_i     <= cur_op.status;
          cq_command_id_i <= cur_op.cid;
          cq_dword0_i     <= cur_op.dw0;
          start_i         <= 1'b1;
          if ($urandom_range(0, 63) == 0) no_idle = !no_idle;
          gap_left = no_idle ? 0 : $urandom_range(0, 3);
        end else begin
          start_i <= 1'b0;
        end
      end
    end
  end

  // monitor
  always @(posedge clk_i) begin
    qp_outcome_t want;
    if (rst_ni && done_o === 1'b1) begin
      if (predicted_outcomes.size() == 0) begin
        errors++;
        $display("%0t unexpected result: expected none actual outcome %0d",
                 $time, outcome_o);
      end else begin
        want = predicted_outcomes.pop_front();
        check_field("outcome", 32'(want.outcome), 32'(outcome_o));
        check_field("command_id", 32'(want.cmd_id), 32'(command_id_o));
        check_field("slot_index", 32'(want.slot), 32'(slot_index_o));
        check_field("tag_out", 32'(want.tag), 32'(tag_out_o));
        check_field("status_out", 32'(want.status), 32'(status_out_o));
        check_field("dword0_out", want.dw0, dword0_out_o);
        check_field("doorbell_write", 32'(want.db_wr), 32'(doorbell_write_o));
        check_field("doorbell_value", 32'(want.db_val), 32'(doorbell_value_o));
        case (outcome_o)
          OUT_SUBMITTED: n_sub++;
          OUT_FULL:      n_full++;
          OUT_CONSUMED:  n_cons++;
          OUT_STALE:     n_stale++;
          default:       n_nonew++;
        endcase
        if (doorbell_write_o === 1'b1) n_db++;
      end
    end
  end

  task automatic add_op(host_op_t op);
    qp_outcome_t unused;
    host_ops.push_back(op);
    unused = apply_host_op(planned, op);
    n_ops++;
  endtask

  task automatic add_submit(logic [TagW-1:0] tag);
    host_op_t op;
    op.action  = ACT_SUBMIT;
    op.req_tag = tag;
    op.phase   = 1'($urandom);
    op.status  = StatusW'($urandom);
    op.cid     = IdxW'($urandom);
    op.dw0     = $urandom;
    add_op(op);
  endtask

  // phase_ok selects the phase the tracker expects, otherwise the stale one
  task automatic add_completion(logic phase_ok, logic [IdxW-1:0] cid,
                                logic [StatusW-1:0] st, logic [DwW-1:0] dw);
    host_op_t op;
    op.action  = ACT_COMPLETE;
    op.req_tag = TagW'($urandom);
    op.phase   = phase_ok ? planned.phase : ~planned.phase;
    op.status  = st;
    op.cid     = cid;
    op.dw0     = dw;
    add_op(op);
  endtask

  task automatic add_random_op(int submit_pct);
    int              n_busy;
    int              roll;
    int              pick;
    int              k;
    logic [IdxW-1:0] cid;
    n_busy = $countones(planned.busy);
    roll = $urandom_range(0, 99);
    if ((n_busy == 0 && roll < 70) || roll < submit_pct) begin
      add_submit(TagW'($urandom));
    end else begin
      roll = $urandom_range(0, 99);
      if (roll < 15) begin
        add_completion(1'b0, IdxW'($urandom), StatusW'($urandom), $urandom);
      end else if (roll < 25 || n_busy == 0) begin
        // id 63 is never allocated, so an idle id always exists
        do cid = IdxW'($urandom); while (planned.busy[cid]);
        add_completion(1'b1, cid, StatusW'($urandom), $urandom);
      end else begin
        pick = $urandom_range(0, n_busy - 1);
        k = 0;
        cid = '0;
        for (int i = 0; i < 64; i++)
          if (planned.busy[i]) begin
            if (k == pick) cid = IdxW'(i);
            k++;
          end
        add_completion(1'b1, cid, StatusW'($urandom), $urandom);
      end
    end
  endtask

  task automatic settle();
    do @(negedge clk_i);
    while (host_ops.size() != 0 || start_i || predicted_outcomes.size() != 0);
  endtask

  task automatic write_size(logic [CfgW-1:0] v);
    settle();
    @(posedge clk_i);
    cfg_we_i    <= 1'b1;
    cfg_wdata_i <= v;
    @(posedge clk_i);
    cfg_we_i    <= 1'b0;
    @(negedge clk_i);
    planned.size = v;
    n_cfg++;
  endtask

  task automatic run_phase(logic [CfgW-1:0] size, int submit_pct, int n);
    write_size(size);
    repeat (n) add_random_op(submit_pct);
  endtask

  initial begin
    tracked = qp_reset_state();
    planned = qp_reset_state();
    repeat (4) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(negedge clk_i);

    // directed: empty queue, stale id, extremes of tag/status/dword, doorbells
    add_completion(1'b0, 6'h3f, '1, '1);
    add_completion(1'b1, 6'h3f, '1, '1);
    add_completion(1'b0, '0, '0, '0);
    add_submit(16'hffff);
    add_submit(16'h0000);
    add_completion(1'b1, 6'd0, 15'h7fff, 32'hffff_ffff);
    add_completion(1'b1, 6'd1, 15'h0000, 32'h0000_0000);
    add_completion(1'b0, 6'd0, '0, '0);
    add_completion(1'b0, 6'd0, '0, '0);
    // shrink with both pointers past the new last slot; full ring; phase wrap
    write_size(CfgW'(2));
    add_submit(16'ha5a5);
    add_submit(16'h5a5a);
    add_completion(1'b1, 6'd0, 15'h2aaa, 32'haaaa_5555);
    add_completion(1'b1, 6'd1, 15'h5555, 32'h5555_aaaa);
    add_completion(1'b1, 6'd62, '0, '0);
    add_completion(1'b0, 6'd0, '0, '0);
    add_submit(16'h1234);
    add_submit(16'h4321);
    add_completion(1'b1, 6'd0, 15'h0001, 32'h0000_0001);
    add_completion(1'b0, 6'd0, '0, '0);

    // random: mostly well-formed completions of outstanding ids
    run_phase(CfgW'(2), 50, 105);
    run_phase(CfgW'(0), 45, 105);
    run_phase(CfgW'(3), 55, 105);
    run_phase(CfgW'(127), 60, 105);
    run_phase(CfgW'(1), 50, 105);
    run_phase(CfgW'(7), 55, 105);
    run_phase(CfgW'(64), 85, 200);
    run_phase(CfgW'($urandom_range(2, 64)), $urandom_range(35, 65), 105);
    run_phase(CfgW'(16), 40, 105);
    run_phase(CfgW'($urandom_range(0, 127)), $urandom_range(35, 65), 105);

    settle();
    repeat (4) @(posedge clk_i);
    $display("%0d transactions: %0d submitted, %0d full, %0d consumed, %0d stale, %0d no new",
             n_ops, n_sub, n_full, n_cons, n_stale, n_nonew);
    $display("%0d doorbell writes, %0d queue size changes", n_db, n_cfg);
    if (errors == 0) begin
      $display("simulation ok");
    end else begin
      $display("simulation failed");
    end
    $finish;
  end

endmodule
